// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hfa_pkg;

    localparam int unsigned HOLES_DEF     = 64;
    localparam int unsigned SIZE_BITS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam logic [9:0]  REQ_NUM_MAX   = 10'd1023;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 2'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [5:0]  hole_number;
        logic [15:0] hole_size;
        logic [15:0] request_size;
    } t_item;

    typedef struct packed {
        logic [9:0]  request_number;
        logic        granted;
        logic [5:0]  hole_index;
        logic [15:0] space_left;
    } t_result;

    // queued command: size is the hole size for a load, the request size for an allocate
    typedef struct packed {
        logic        kind;
        logic [5:0]  hole_number;
        logic [15:0] size;
        logic [9:0]  req_num;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/hfa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfa_front
    import hfa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_cmd       o_head,
    output logic       o_head_valid,
    output logic       o_full
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_queue [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic [9:0]    r_req_cnt, n_req_cnt;
    t_cmd          w_entry;
    logic          w_pop;

    assign w_pop        = i_pop && (r_count != '0);
    assign o_head       = r_queue[r_rptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == CW'(QUEUE_DEPTH));

    always_comb begin
        w_entry.kind        = i_item.kind;
        w_entry.hole_number = i_item.hole_number;
        w_entry.size        = (i_item.kind == KIND_LOAD) ? i_item.hole_size
                                                         : i_item.request_size;
        w_entry.req_num     = r_req_cnt;
    end

    always_comb begin
        n_req_cnt = r_req_cnt;
        if (i_accept) begin
            if (i_item.kind == KIND_LOAD) begin
                n_req_cnt = '0;
            end else if (r_req_cnt != REQ_NUM_MAX) begin
                n_req_cnt = r_req_cnt + 10'd1;
            end
        end
    end

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_accept) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_accept && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_accept && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_count   <= '0;
            r_req_cnt <= '0;
        end else begin
            r_wptr    <= n_wptr;
            r_rptr    <= n_rptr;
            r_count   <= n_count;
            r_req_cnt <= n_req_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_queue[r_wptr] <= w_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hfa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfa_back
    import hfa_pkg::*;
#(
    parameter int unsigned HOLES     = HOLES_DEF,
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_fit_mode,
    input  wire logic [6:0] i_hole_count,
    input  wire t_cmd       i_head,
    input  wire logic       i_head_valid,
    output logic            o_pop,
    output logic            o_done,
    output t_result         o_result
);

    localparam int unsigned IW = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int unsigned CW = $clog2(HOLES + 1);

    logic [SIZE_BITS-1:0] r_mem [HOLES];

    t_back_state          r_state, n_state;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_issue;
    logic [SIZE_BITS-1:0] r_req;
    logic [9:0]           r_req_num;
    logic                 r_found;
    logic [IW-1:0]        r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic                 r_vld;
    logic [IW-1:0]        r_vaddr;
    logic [SIZE_BITS-1:0] r_rdata;
    logic                 r_done;
    t_result              r_result;

    logic [CW-1:0]        w_n;
    logic                 w_start_alloc;
    logic                 w_take;
    logic                 w_rd_en;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    logic [SIZE_BITS-1:0] w_wdata;
    logic [SIZE_BITS-1:0] w_left;

    // holes searched: hole_count capped at the table depth
    always_comb begin
        if (32'(i_hole_count) > 32'(HOLES)) begin
            w_n = CW'(HOLES);
        end else begin
            w_n = CW'(i_hole_count);
        end
    end

    assign w_start_alloc = (r_state == S_IDLE) && i_head_valid && (i_head.kind == KIND_ALLOC);
    assign w_left        = r_best - r_req;

    // compare the entry read last cycle against the current pick
    always_comb begin
        w_take = 1'b0;
        if (r_vld && (r_req <= r_rdata)) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else if (i_fit_mode == FIT_BEST && r_rdata < r_best) begin
                w_take = 1'b1;
            end else if (i_fit_mode == FIT_WORST && r_rdata > r_best) begin
                w_take = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start_alloc) begin
                    n_state = (w_n == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_issue == r_n - 1'b1) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        w_rd_en   = 1'b0;
        w_rd_addr = r_issue[IW-1:0];
        w_we      = 1'b0;
        w_waddr   = IW'(i_head.hole_number);
        w_wdata   = SIZE_BITS'(i_head.size);
        case (r_state)
            S_IDLE: begin
                o_pop = i_head_valid;
                if (i_head_valid && i_head.kind == KIND_LOAD
                        && 32'(i_head.hole_number) < 32'(HOLES)) begin
                    w_we = 1'b1;
                end
            end
            S_SCAN: begin
                w_rd_en = 1'b1;
            end
            S_DONE: begin
                w_we    = r_found;
                w_waddr = r_pick;
                w_wdata = w_left;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= w_rd_en;
            r_done  <= (r_state == S_DONE);
            if (w_start_alloc) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vaddr <= w_rd_addr;
        if (w_start_alloc) begin
            r_n       <= w_n;
            r_issue   <= '0;
            r_req     <= SIZE_BITS'(i_head.size);
            r_req_num <= i_head.req_num;
        end else if (w_rd_en) begin
            r_issue <= r_issue + 1'b1;
        end
        if (w_take) begin
            r_pick <= r_vaddr;
            r_best <= r_rdata;
        end
        if (r_state == S_DONE) begin
            r_result.request_number <= r_req_num;
            r_result.granted        <= r_found;
            r_result.hole_index     <= r_found ? 6'(r_pick) : 6'd0;
            r_result.space_left     <= r_found ? 16'(w_left) : 16'd0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/hole_fit_allocator.sv =====
// channel  direction  handshake                 payload
// item     in         start high, busy low      i_item (t_item)
// result   out        o_done, one cycle         o_result (t_result)
// config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// a load is written into the hole table from the idle state; an allocate runs a one-read-a-cycle
// scan of the hole table over n holes, n being hole_count capped at HOLES, then a flush and a
// done state (it goes straight to done when n is zero)
// a two-entry command queue sits in front, so busy rises only while it is full
// reset is synchronous and active low; the hole table needs no clearing pass
// the result is shown for one cycle after o_done rises and cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hole_fit_allocator
    import hfa_pkg::*;
#(
    parameter int unsigned HOLES     = HOLES_DEF,
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_done,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0] r_fit_mode;
    logic [6:0] r_hole_count;
    logic       w_accept;
    logic       w_pop;
    logic       w_full;
    logic       w_head_valid;
    t_cmd       w_head;

    assign w_accept = start && !busy;
    assign busy     = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= FIT_FIRST;
            r_hole_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FIT_MODE) begin
                r_fit_mode <= i_cfg_data[1:0];
            end else if (i_cfg_idx == CFG_HOLE_COUNT) begin
                r_hole_count <= i_cfg_data[6:0];
            end
        end
    end

    hfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_item       (i_item),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    hfa_back #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fit_mode   (r_fit_mode),
        .i_hole_count (r_hole_count),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_result     (o_result)
    );

    `ASSERT_IMP(a_miss_zero, o_done && !o_result.granted,
        o_result.hole_index == 6'd0 && o_result.space_left == 16'd0,
        "refused transfer carries nonzero hole or space")
    `ASSERT_NXT(a_done_single, o_done, !o_done, "result strobe held two cycles")
    `ASSERT_IMP(a_busy_queued, busy, w_head_valid, "busy with an empty command queue")
    `ASSERT_NXT(a_full_blocks, busy && !w_pop, busy, "queue drained without a pop")

endmodule

`default_nettype wire

// ===== sim/tb_hole_fit_allocator.sv =====
`timescale 1ns / 1ps

module tb_hole_fit_allocator;
    import hfa_pkg::*;

    localparam int unsigned HOLES = HOLES_DEF;
    // a full queue of scans plus a few loads still in flight after the last result
    localparam int DRAIN_CYCLES = 2 * (HOLES + 3) + 8;
    localparam int MAX_SHOWN = 10;
    localparam logic [1:0] FIT_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the allocator state
    logic [15:0] space_tbl [HOLES];
    logic [9:0]  req_seq;
    logic [1:0]  mode_sh;
    logic [6:0]  count_sh;
    t_result     grant_q[$];
    int          mismatches;
    bit          no_idle;

    hole_fit_allocator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_done    (o_done),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int active_holes();
        return (count_sh > HOLES) ? HOLES : int'(count_sh);
    endfunction

    // search the shadow table by the current policy and queue the outcome
    task automatic predict_alloc(input logic [15:0] req);
        t_result r;
        int      n;
        bit      found;
        int      pick;
        n = active_holes();
        found = 1'b0;
        pick = 0;
        for (int j = 0; j < n; j++) begin
            if (req > space_tbl[j]) continue;
            if (!found) begin
                found = 1'b1;
                pick = j;
                if (mode_sh != FIT_BEST && mode_sh != FIT_WORST) break;
            end else if (mode_sh == FIT_BEST && space_tbl[j] < space_tbl[pick]) begin
                pick = j;
            end else if (mode_sh == FIT_WORST && space_tbl[j] > space_tbl[pick]) begin
                pick = j;
            end
        end
        r.request_number = req_seq;
        r.granted = found;
        r.hole_index = found ? 6'(pick) : 6'd0;
        r.space_left = 16'd0;
        if (found) begin
            space_tbl[pick] = space_tbl[pick] - req;
            r.space_left = space_tbl[pick];
        end
        grant_q.push_back(r);
        if (req_seq != REQ_NUM_MAX) req_seq++;
    endtask

    // entered and left at a falling edge
    task automatic send_item(input t_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        if (it.kind == KIND_ALLOC) begin
            predict_alloc(it.request_size);
        end else begin
            space_tbl[it.hole_number] = it.hole_size;
            req_seq = 10'd0;
        end
        @(negedge i_clk);
    endtask

    task automatic load_hole(input int num, input logic [15:0] size);
        t_item it;
        it.kind = KIND_LOAD;
        it.hole_number = 6'(num);
        it.hole_size = size;
        it.request_size = 16'($urandom());
        send_item(it);
    endtask

    task automatic alloc(input logic [15:0] size);
        t_item it;
        it.kind = KIND_ALLOC;
        it.hole_number = 6'($urandom());
        it.hole_size = 16'($urandom());
        it.request_size = size;
        send_item(it);
    endtask

    // hold off until every result is in and the queue has emptied
    task automatic drain();
        start = 1'b0;
        while (grant_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_FIT_MODE) begin
            mode_sh = val[1:0];
        end else if (idx == CFG_HOLE_COUNT) begin
            count_sh = val;
        end
    endtask

    task automatic set_policy(input logic [1:0] mode, input logic [6:0] count);
        drain();
        write_cfg(CFG_FIT_MODE, CFG_DATA_W'(mode));
        write_cfg(CFG_HOLE_COUNT, count);
    endtask

    function automatic logic [15:0] pick_hole_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return 16'($urandom_range(0, 4095));
        if (sel < 15) return 16'($urandom());
        if (sel < 17) return 16'd0;
        if (sel < 19) return 16'hFFFF;
        return 16'($urandom_range(0, 15));
    endfunction

    // half the time a size near what an active hole holds, so grants and misses both happen
    function automatic logic [15:0] pick_request();
        int          sel;
        logic [15:0] sp;
        sel = $urandom_range(0, 9);
        if (sel < 5 && active_holes() != 0) begin
            sp = space_tbl[$urandom_range(0, active_holes() - 1)];
            if ($urandom_range(0, 3) == 0) return sp + 16'd1;
            return 16'($urandom_range(0, sp));
        end
        if (sel < 7) return 16'($urandom_range(0, 255));
        if (sel == 7) return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        return 16'($urandom());
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: num %0d grant %0b hole %0d left %0d",
                             o_result.request_number, o_result.granted,
                             o_result.hole_index, o_result.space_left);
            end else begin
                want = grant_q.pop_front();
                if (o_result.request_number !== want.request_number ||
                    o_result.granted !== want.granted ||
                    o_result.hole_index !== want.hole_index ||
                    o_result.space_left !== want.space_left) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $write("mismatch: expected num %0d grant %0b hole %0d left %0d,",
                               want.request_number, want.granted, want.hole_index,
                               want.space_left);
                        $display(" got num %0d grant %0b hole %0d left %0d",
                                 o_result.request_number, o_result.granted,
                                 o_result.hole_index, o_result.space_left);
                    end
                end
            end
        end
    end

    // nothing searched while the count is still zero from reset
    task automatic test_empty_table();
        alloc(16'd0);
        alloc(16'hFFFF);
    endtask

    task automatic test_first_fit();
        load_hole(0, 16'd100);
        load_hole(1, 16'd40);
        load_hole(2, 16'hFFFF);
        load_hole(3, 16'd0);
        set_policy(FIT_FIRST, 7'd4);
        alloc(16'd50);
        alloc(16'd0);
        alloc(16'd60);
    endtask

    task automatic test_best_fit();
        set_policy(FIT_BEST, 7'd4);
        alloc(16'd30);
        alloc(16'd0);
        load_hole(1, 16'd50);
        alloc(16'd50);
    endtask

    task automatic test_worst_fit();
        set_policy(FIT_WORST, 7'd4);
        alloc(16'd1);
        load_hole(0, 16'd65474);
        alloc(16'd4);
        alloc(16'd0);
    endtask

    task automatic test_no_fit_and_unused_mode();
        alloc(16'hFFFF);
        set_policy(FIT_UNUSED, 7'd4);
        alloc(16'd5);
        alloc(16'd0);
    endtask

    // every hole written before any wider search
    task automatic test_fill_table();
        for (int h = 0; h < HOLES; h++) load_hole(h, pick_hole_size());
    endtask

    task automatic test_counter_saturation();
        set_policy(FIT_FIRST, 7'd1);
        no_idle = 1'b1;
        load_hole(0, 16'hFFFF);
        for (int k = 0; k < 1030; k++) alloc(16'($urandom_range(0, 63)));
        no_idle = 1'b0;
        load_hole(0, 16'd1000);
        alloc(16'd10);
        alloc(16'd2000);
    endtask

    task automatic test_random_traffic();
        logic [1:0] m;
        logic [6:0] c;
        int         n;
        for (int phase = 0; phase < 20; phase++) begin
            m = (phase < 8) ? 2'(phase % 4) : 2'($urandom_range(0, 3));
            case (phase % 5)
                0: c = (phase == 0) ? 7'd127 : 7'($urandom_range(HOLES + 1, 127));
                1: c = (phase == 1) ? 7'd0 : 7'($urandom_range(0, 2));
                2: c = 7'(HOLES);
                default: c = 7'($urandom_range(1, HOLES));
            endcase
            set_policy(m, c);
            no_idle = (phase % 4 == 3);
            n = active_holes();
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    if (n != 0 && $urandom_range(0, 9) < 7)
                        load_hole($urandom_range(0, n - 1), pick_hole_size());
                    else
                        load_hole($urandom_range(0, HOLES - 1), pick_hole_size());
                end else begin
                    alloc(pick_request());
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        no_idle = 1'b0;
        mismatches = 0;
        req_seq = 10'd0;
        mode_sh = FIT_FIRST;
        count_sh = 7'd0;
        for (int h = 0; h < HOLES; h++) space_tbl[h] = 16'd0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_first_fit();
        test_best_fit();
        test_worst_fit();
        test_no_fit_and_unused_mode();
        test_fill_table();
        test_counter_saturation();
        test_random_traffic();

        drain();
        mismatches += grant_q.size();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hfa_pkg.sv
rtl/hfa_front.sv
rtl/hfa_back.sv
rtl/hole_fit_allocator.sv
sim/tb_hole_fit_allocator.sv
